### sv/samt_pkg.sv
// Shared types and constants of the source-address match table.
package samt_pkg;

   localparam int SHORT_SLOTS_DEF = 24;
   localparam int EXT_SLOTS_DEF   = 12;

   localparam int WORD_W    = 32;
   localparam int SADDR_W   = 16;
   localparam int EADDR_W   = 64;
   localparam int PAN_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 5;
   localparam int SMASK_W   = 24;
   localparam int EMASK_W   = 12;
   localparam int REQ_W     = 3;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD_SHORT     = 3'd0,
      REQ_ADD_EXT       = 3'd1,
      REQ_CLR_SHORT     = 3'd2,
      REQ_CLR_EXT       = 3'd3,
      REQ_CLR_ALL_SHORT = 3'd4,
      REQ_CLR_ALL_EXT   = 3'd5,
      REQ_FIND_SHORT    = 3'd6,
      REQ_FIND_EXT      = 3'd7
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // write enables of the even and odd word banks
   typedef struct packed {
      logic even;
      logic odd;
   } store_wen_type;

endpackage

### sv/samt_if.sv
// Channel interfaces: request, response and configuration write.
interface samt_req_if
   import samt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [SADDR_W-1:0]   short_address;
   logic [EADDR_W-1:0]   ext_address;

   modport source (output valid, req_type, short_address, ext_address, input ready);
   modport sink   (input valid, req_type, short_address, ext_address, output ready);
endinterface

interface samt_rsp_if
   import samt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [INDEX_W-1:0]   entry_index;
   logic [SMASK_W-1:0]   short_enable_mask;
   logic [EMASK_W-1:0]   ext_enable_mask;

   modport source (output valid, status, entry_index, short_enable_mask, ext_enable_mask,
                   input ready);
   modport sink   (input valid, status, entry_index, short_enable_mask, ext_enable_mask,
                   output ready);
endinterface

interface samt_csr_if
   import samt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [PAN_W-1:0]     pan_id;

   modport source (output valid, pan_id, input ready);
   modport sink   (input valid, pan_id, output ready);
endinterface

### sv/samt_store.sv
// Address store: even and odd 32-bit word banks, one write and one registered read per cycle.
module samt_store
   import samt_pkg::*;
#(
   parameter int ROWS  = SHORT_SLOTS_DEF / 2,
   parameter int ROW_W = 4
) (
   input  logic                clock,
   input  store_wen_type       wen,
   input  logic [ROW_W-1:0]    wr_row,
   input  logic [WORD_W-1:0]   wr_even,
   input  logic [WORD_W-1:0]   wr_odd,
   input  logic [ROW_W-1:0]    rd_row,
   output logic [WORD_W-1:0]   rd_even,
   output logic [WORD_W-1:0]   rd_odd
);

   logic [WORD_W-1:0] mem_even [ROWS];
   logic [WORD_W-1:0] mem_odd  [ROWS];
   logic [WORD_W-1:0] rd_even_ff;
   logic [WORD_W-1:0] rd_odd_ff;

   always_ff @(posedge clock) begin
      if (wen.even) begin
         mem_even[wr_row] <= wr_even;
      end
      if (wen.odd) begin
         mem_odd[wr_row] <= wr_odd;
      end
      rd_even_ff <= mem_even[rd_row];
      rd_odd_ff  <= mem_odd[rd_row];
   end

   assign rd_even = rd_even_ff;
   assign rd_odd  = rd_odd_ff;

endmodule

### sv/samt_ctrl.sv
// Operation sequencer: slot scan over the store, enable bitmaps and response register.
module samt_ctrl
   import samt_pkg::*;
#(
   parameter int SHORT_SLOTS = SHORT_SLOTS_DEF,
   parameter int EXT_SLOTS   = EXT_SLOTS_DEF,
   parameter int ROW_W       = 4
) (
   input  logic               clock,
   input  logic               reset,
   samt_req_if.sink           req_ch,
   samt_rsp_if.source         rsp_ch,
   input  logic [PAN_W-1:0]   pan_id,
   output store_wen_type      wen,
   output logic [ROW_W-1:0]   wr_row,
   output logic [WORD_W-1:0]  wr_even,
   output logic [WORD_W-1:0]  wr_odd,
   output logic [ROW_W-1:0]   rd_row,
   input  logic [WORD_W-1:0]  rd_even,
   input  logic [WORD_W-1:0]  rd_odd
);

   localparam int SCAN_N = (SHORT_SLOTS > EXT_SLOTS) ? SHORT_SLOTS : EXT_SLOTS;
   localparam int IDX_W  = $clog2(SCAN_N);
   localparam int PAD_W  = 2 * SCAN_N;
   localparam logic [IDX_W-1:0] LAST_SHORT = IDX_W'(SHORT_SLOTS - 1);
   localparam logic [IDX_W-1:0] LAST_EXT   = IDX_W'(EXT_SLOTS - 1);

   state_type              state_ff, state_in;
   req_code_type           op_ff, op_in;
   logic [SADDR_W-1:0]     saddr_ff, saddr_in;
   logic [EADDR_W-1:0]     eaddr_ff, eaddr_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [SHORT_SLOTS-1:0] short_en_ff, short_en_in;
   logic [EXT_SLOTS-1:0]   ext_en_ff, ext_en_in;
   status_type             status_ff, status_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [SMASK_W-1:0]     rsp_smask_ff, rsp_smask_in;
   logic [EMASK_W-1:0]     rsp_emask_ff, rsp_emask_in;

   logic                   is_ext, is_add, is_clear, is_clr_all;
   logic [IDX_W-1:0]       last_idx;
   logic [PAD_W-1:0]       s_pad, e_pad;
   logic [SCAN_N-1:0]      cand_vec, en_vec;
   logic [WORD_W-1:0]      short_word;
   logic                   data_match, hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         chk_vld_ff  <= 1'b0;
         short_en_ff <= '0;
         ext_en_ff   <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         chk_vld_ff  <= chk_vld_in;
         short_en_ff <= short_en_in;
         ext_en_ff   <= ext_en_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      op_ff         <= op_in;
      saddr_ff      <= saddr_in;
      eaddr_ff      <= eaddr_in;
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      status_ff     <= status_in;
      index_ff      <= index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_smask_ff  <= rsp_smask_in;
      rsp_emask_ff  <= rsp_emask_in;
   end

   // operation decode
   always_comb begin
      is_ext     = op_ff inside {REQ_ADD_EXT, REQ_CLR_EXT, REQ_CLR_ALL_EXT, REQ_FIND_EXT};
      is_add     = op_ff inside {REQ_ADD_SHORT, REQ_ADD_EXT};
      is_clear   = op_ff inside {REQ_CLR_SHORT, REQ_CLR_EXT};
      is_clr_all = op_ff inside {REQ_CLR_ALL_SHORT, REQ_CLR_ALL_EXT};
      last_idx   = is_ext ? LAST_EXT : LAST_SHORT;
   end

   // per-slot free and enabled flags; an extended entry overlays short slots 2i and 2i+1
   always_comb begin
      s_pad = PAD_W'(short_en_ff);
      e_pad = PAD_W'(ext_en_ff);
      for (int i = 0; i < SCAN_N; i++) begin
         if (is_ext) begin
            cand_vec[i] = (i < EXT_SLOTS) && !e_pad[i] && !s_pad[2*i] && !s_pad[2*i+1];
            en_vec[i]   = e_pad[i];
         end else begin
            cand_vec[i] = (i < SHORT_SLOTS) && !s_pad[i] && !e_pad[i/2];
            en_vec[i]   = s_pad[i];
         end
      end
   end

   // compare stage works one slot behind the read address
   always_comb begin
      short_word = chk_idx_ff[0] ? rd_odd : rd_even;
      if (is_ext) begin
         data_match = ({rd_odd, rd_even} == eaddr_ff);
      end else begin
         data_match = (short_word[WORD_W-1:SADDR_W] == saddr_ff);
      end
      hit = is_add ? cand_vec[chk_idx_ff] : (en_vec[chk_idx_ff] && data_match);
   end

   assign rd_row  = is_ext ? ROW_W'(idx_ff) : ROW_W'(idx_ff >> 1);
   assign wr_row  = is_ext ? ROW_W'(chk_idx_ff) : ROW_W'(chk_idx_ff >> 1);
   assign wr_even = is_ext ? eaddr_ff[WORD_W-1:0] : {saddr_ff, pan_id};
   assign wr_odd  = is_ext ? eaddr_ff[EADDR_W-1:WORD_W] : {saddr_ff, pan_id};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      saddr_in      = saddr_ff;
      eaddr_in      = eaddr_ff;
      idx_in        = idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      short_en_in   = short_en_ff;
      ext_en_in     = ext_en_ff;
      status_in     = status_ff;
      index_in      = index_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_smask_in  = rsp_smask_ff;
      rsp_emask_in  = rsp_emask_ff;
      wen           = '0;
      req_ch.ready  = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in      = req_code_type'(req_ch.req_type);
               saddr_in   = req_ch.short_address;
               eaddr_in   = req_ch.ext_address;
               idx_in     = '0;
               chk_vld_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = idx_ff;
            if (idx_ff != last_idx) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            if (is_clr_all) begin
               if (is_ext) begin
                  ext_en_in = '0;
               end else begin
                  short_en_in = '0;
               end
               status_in  = ST_OK;
               index_in   = '0;
               chk_vld_in = 1'b0;
               state_in   = S_DONE;
            end else if (chk_vld_ff && (hit || chk_idx_ff == last_idx)) begin
               chk_vld_in = 1'b0;
               state_in   = S_DONE;
               if (hit) begin
                  status_in = ST_OK;
                  index_in  = INDEX_W'(chk_idx_ff);
                  if (is_add || is_clear) begin
                     if (is_ext) begin
                        for (int i = 0; i < EXT_SLOTS; i++) begin
                           if (chk_idx_ff == IDX_W'(i)) begin
                              ext_en_in[i] = is_add;
                           end
                        end
                     end else begin
                        for (int i = 0; i < SHORT_SLOTS; i++) begin
                           if (chk_idx_ff == IDX_W'(i)) begin
                              short_en_in[i] = is_add;
                           end
                        end
                     end
                  end
                  if (is_add) begin
                     wen.even = is_ext || !chk_idx_ff[0];
                     wen.odd  = is_ext || chk_idx_ff[0];
                  end
               end else begin
                  status_in = is_add ? ST_FULL : ST_NOT_FOUND;
                  index_in  = '0;
               end
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = index_ff;
               rsp_smask_in  = SMASK_W'(short_en_ff);
               rsp_emask_in  = EMASK_W'(ext_en_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid             = rsp_vld_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.entry_index       = rsp_index_ff;
   assign rsp_ch.short_enable_mask = rsp_smask_ff;
   assign rsp_ch.ext_enable_mask   = rsp_emask_ff;

endmodule

### sv/source_address_match_table_core.sv
// Top level of the source-address match table: PAN register, sequencer and address store.
//
// Usage:
//   req_ch  carries one operation per transfer: add, clear, clear-all or find, for
//           short or extended addresses.
//   rsp_ch  returns one result per operation: status, slot index and both enable
//           bitmaps as they stand after the operation.
//   csr_ch  writes the PAN ID stored with new short entries; always ready, write
//           it only while no operation is in flight.
// Throughput: one operation at a time. Adds, clears and finds scan the
//   slots of their kind through the store read port, one slot per cycle with the
//   compare one slot behind the read; a scan stops at the first matching slot (a free
//   one for adds) or at the last slot of its kind. Clear-all operations do not scan.
// Reset: enable bitmaps clear, PAN ID is zero; the store itself is not cleared,
//   as only enabled entries are ever compared.
// Stall: the result sits in an output register; the next request is accepted while
//   it waits, and that operation's scan completes and holds until the register frees.
module source_address_match_table_core
   import samt_pkg::*;
#(
   parameter int SHORT_SLOTS = SHORT_SLOTS_DEF,
   parameter int EXT_SLOTS   = EXT_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   samt_req_if.sink    req_ch,
   samt_rsp_if.source  rsp_ch,
   samt_csr_if.sink    csr_ch
);

   localparam int SHORT_ROWS = (SHORT_SLOTS + 1) / 2;
   localparam int ROWS       = (SHORT_ROWS > EXT_SLOTS) ? SHORT_ROWS : EXT_SLOTS;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [PAN_W-1:0]  pan_id_ff, pan_id_in;
   store_wen_type     wen;
   logic [ROW_W-1:0]  wr_row, rd_row;
   logic [WORD_W-1:0] wr_even, wr_odd, rd_even, rd_odd;

   assign csr_ch.ready = 1'b1;
   assign pan_id_in    = (csr_ch.valid && csr_ch.ready) ? csr_ch.pan_id : pan_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_id_ff <= '0;
      end else begin
         pan_id_ff <= pan_id_in;
      end
   end

   samt_ctrl #(
      .SHORT_SLOTS (SHORT_SLOTS),
      .EXT_SLOTS   (EXT_SLOTS),
      .ROW_W       (ROW_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .pan_id  (pan_id_ff),
      .wen     (wen),
      .wr_row  (wr_row),
      .wr_even (wr_even),
      .wr_odd  (wr_odd),
      .rd_row  (rd_row),
      .rd_even (rd_even),
      .rd_odd  (rd_odd)
   );

   samt_store #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_store (
      .clock   (clock),
      .wen     (wen),
      .wr_row  (wr_row),
      .wr_even (wr_even),
      .wr_odd  (wr_odd),
      .rd_row  (rd_row),
      .rd_even (rd_even),
      .rd_odd  (rd_odd)
   );

endmodule

### tb/tb.sv
// Self-checking testbench for the source-address match table core.
`timescale 1ns / 100ps

module tb
   import samt_pkg::*;
();

   localparam int NS           = SHORT_SLOTS_DEF;
   localparam int NE           = EXT_SLOTS_DEF;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   entry_index;
      logic [SMASK_W-1:0]   short_mask;
      logic [EMASK_W-1:0]   ext_mask;
   } table_result_type;

   logic clock;
   logic reset;

   samt_req_if req_ch ();
   samt_rsp_if rsp_ch ();
   samt_csr_if csr_ch ();

   source_address_match_table_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the table
   logic [WORD_W-1:0]  store_m [NS];
   logic [SMASK_W-1:0] short_en_m;
   logic [EMASK_W-1:0] ext_en_m;
   logic [PAN_W-1:0]   pan_m;

   table_result_type pending_results [$];

   logic [SADDR_W-1:0] short_pool [8];
   logic [EADDR_W-1:0] ext_pool [8];

   int error_count;
   int ops_sent;
   int results_checked;
   int full_count;
   int miss_count;
   int req_idle_pct;
   int rsp_stall_pct;
   int holds_requested;
   int holds_served;
   int rsp_hold_left;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int lookup_short(input logic [SADDR_W-1:0] addr);
      int i;
      for (i = 0; i < NS; i++)
         if (short_en_m[i] && store_m[i][31:16] == addr)
            return i;
      return -1;
   endfunction

   function automatic int lookup_ext(input logic [EADDR_W-1:0] addr);
      int i;
      for (i = 0; i < NE; i++)
         if (ext_en_m[i] && {store_m[2*i+1], store_m[2*i]} == addr)
            return i;
      return -1;
   endfunction

   function automatic table_result_type apply_table_op(input req_code_type op,
                                                       input logic [SADDR_W-1:0] sa,
                                                       input logic [EADDR_W-1:0] ea);
      table_result_type r;
      int slot;
      int i;
      r = '0;
      r.status = ST_OK;
      slot = -1;
      case (op)
         REQ_ADD_SHORT: begin
            // free only if its own bit and the covering extended entry are clear
            for (i = 0; i < NS; i++)
               if (slot < 0 && !short_en_m[i] && !(i / 2 < NE && ext_en_m[i / 2]))
                  slot = i;
            if (slot >= 0) begin
               store_m[slot] = {sa, pan_m};
               short_en_m[slot] = 1'b1;
            end
         end
         REQ_ADD_EXT: begin
            for (i = 0; i < NE; i++)
               if (slot < 0 && !ext_en_m[i] && short_en_m[2*i +: 2] == 2'b00)
                  slot = i;
            if (slot >= 0) begin
               store_m[2*slot]   = ea[31:0];
               store_m[2*slot+1] = ea[63:32];
               ext_en_m[slot] = 1'b1;
            end
         end
         REQ_CLR_SHORT: begin
            slot = lookup_short(sa);
            if (slot >= 0)
               short_en_m[slot] = 1'b0;
         end
         REQ_CLR_EXT: begin
            slot = lookup_ext(ea);
            if (slot >= 0)
               ext_en_m[slot] = 1'b0;
         end
         REQ_CLR_ALL_SHORT: begin
            short_en_m = '0;
            slot = 0;
         end
         REQ_CLR_ALL_EXT: begin
            ext_en_m = '0;
            slot = 0;
         end
         REQ_FIND_SHORT: slot = lookup_short(sa);
         default:        slot = lookup_ext(ea);
      endcase
      if (slot < 0) begin
         if (op == REQ_ADD_SHORT || op == REQ_ADD_EXT) begin
            r.status = ST_FULL;
            full_count++;
         end else begin
            r.status = ST_NOT_FOUND;
            miss_count++;
         end
      end else begin
         r.entry_index = INDEX_W'(slot);
      end
      r.short_mask = short_en_m;
      r.ext_mask   = ext_en_m;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_op(input req_code_type op, input logic [SADDR_W-1:0] sa,
                          input logic [EADDR_W-1:0] ea);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      // now and then a long gap so offers land on every phase of a scan
      if (req_idle_pct > 0 && $urandom_range(9) == 0)
         gap += $urandom_range(35);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= op;
      req_ch.short_address <= sa;
      req_ch.ext_address   <= ea;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(apply_table_op(op, sa, ea));
      ops_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_pan(input logic [PAN_W-1:0] value);
      csr_ch.valid  <= 1'b1;
      csr_ch.pan_id <= value;
      do @(posedge clock); while (!csr_ch.ready);
      pan_m = value;
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- checker

   function automatic void check_field(input string name, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (expected !== actual) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, expected,
                  actual);
      end
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         rsp_ch.ready  <= 1'b0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected, status %0d index %0d", $time,
                        rsp_ch.status, rsp_ch.entry_index);
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("entry_index", want.entry_index, rsp_ch.entry_index);
               check_field("short_enable_mask", want.short_mask, rsp_ch.short_enable_mask);
               check_field("ext_enable_mask", want.ext_mask, rsp_ch.ext_enable_mask);
               results_checked++;
            end
         end
         if (holds_served != holds_requested) begin
            holds_served++;
            rsp_hold_left = HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [SADDR_W-1:0] pick_short();
      if ($urandom_range(4) == 0)
         return SADDR_W'($urandom);
      return short_pool[$urandom_range(7)];
   endfunction

   function automatic logic [EADDR_W-1:0] pick_ext();
      if ($urandom_range(4) == 0)
         return {$urandom, $urandom};
      return ext_pool[$urandom_range(7)];
   endfunction

   function automatic req_code_type pick_op(input bit fill);
      int w;
      w = $urandom_range(99);
      if (fill) begin
         if (w < 35) return REQ_ADD_SHORT;
         if (w < 65) return REQ_ADD_EXT;
         if (w < 75) return REQ_FIND_SHORT;
         if (w < 85) return REQ_FIND_EXT;
         if (w < 93) return REQ_CLR_SHORT;
         return REQ_CLR_EXT;
      end
      if (w < 15) return REQ_ADD_SHORT;
      if (w < 25) return REQ_ADD_EXT;
      if (w < 45) return REQ_CLR_SHORT;
      if (w < 60) return REQ_CLR_EXT;
      if (w < 64) return REQ_CLR_ALL_SHORT;
      if (w < 68) return REQ_CLR_ALL_EXT;
      if (w < 84) return REQ_FIND_SHORT;
      return REQ_FIND_EXT;
   endfunction

   task automatic test_empty_table();
      send_op(REQ_FIND_SHORT, 16'h1234, 64'h0);
      send_op(REQ_FIND_EXT, 16'h0, 64'h0011_2233_4455_6677);
      send_op(REQ_CLR_SHORT, 16'h1234, 64'h0);
      send_op(REQ_CLR_EXT, 16'h0, 64'h0011_2233_4455_6677);
      send_op(REQ_CLR_ALL_SHORT, 16'h0, 64'h0);
      send_op(REQ_CLR_ALL_EXT, 16'h0, 64'h0);
      wait_idle();
   endtask

   task automatic test_overlay_and_matching();
      write_pan(16'hFFFF);
      send_op(REQ_ADD_SHORT, 16'hFFFF, '1);
      send_op(REQ_ADD_SHORT, 16'h0000, '0);
      send_op(REQ_ADD_SHORT, 16'hFFFF, 64'h0);   // duplicate address
      send_op(REQ_ADD_EXT, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(REQ_ADD_EXT, 16'hFFFF, 64'h0);
      send_op(REQ_ADD_SHORT, 16'h5A5A, 64'h0);
      send_op(REQ_FIND_SHORT, 16'hFFFF, 64'h0);  // first of the duplicates
      send_op(REQ_CLR_SHORT, 16'hFFFF, 64'h0);
      send_op(REQ_FIND_SHORT, 16'hFFFF, 64'h0);
      send_op(REQ_FIND_EXT, 16'h0, 64'h0);
      send_op(REQ_CLR_EXT, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(REQ_ADD_EXT, 16'h0, 64'h0123_4567_89AB_CDEF);
      wait_idle();
      write_pan(16'h0000);
      send_op(REQ_ADD_SHORT, 16'h8000, 64'h0);
      send_op(REQ_FIND_SHORT, 16'h0000, 64'h0);
      send_op(REQ_CLR_ALL_SHORT, 16'h0, 64'h0);
      send_op(REQ_FIND_SHORT, 16'h0000, 64'h0);
      send_op(REQ_CLR_ALL_EXT, 16'h0, 64'h0);
      send_op(REQ_FIND_EXT, 16'h0, 64'h0);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      int k;
      bit fill;
      fill = 1'b0;
      write_pan(PAN_W'($urandom));
      for (k = 0; k < 8; k++) begin
         short_pool[k] = SADDR_W'($urandom);
         ext_pool[k]   = {$urandom, $urandom};
      end
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (k = 0; k < count; k++) begin
         // every 30 operations, choose at random between filling the table and churning it
         if (k % 30 == 0)
            fill = $urandom_range(1);
         send_op(pick_op(fill), pick_short(), pick_ext());
      end
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      int k;
      req_idle_pct    = 0;
      rsp_stall_pct   = 0;
      holds_requested = holds_requested + 1;
      for (k = 0; k < 40; k++)
         send_op(pick_op($urandom_range(1)), pick_short(), pick_ext());
      wait_idle();
   endtask

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= REQ_FIND_SHORT;
      req_ch.short_address <= '0;
      req_ch.ext_address   <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.pan_id        <= '0;
      short_en_m      = '0;
      ext_en_m        = '0;
      pan_m           = '0;
      error_count     = 0;
      ops_sent        = 0;
      results_checked = 0;
      full_count      = 0;
      miss_count      = 0;
      req_idle_pct    = 0;
      rsp_stall_pct   = 0;
      holds_requested = 0;
      holds_served    = 0;
      cycle_count     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_overlay_and_matching();
      test_random_traffic(400, 0, 0);
      test_random_traffic(400, 78, 0);
      test_random_traffic(400, 0, 78);
      test_random_traffic(400, 18, 18);
      test_output_backpressure();
      test_random_traffic(20, 0, 0);

      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d operations with %0d results checked across idle and stall mixes",
               ops_sent, results_checked);
      $display("including a long result hold; %0d adds hit a full table, %0d lookups missed",
               full_count, miss_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
